[hw/rtl/line_rasterizer_assert.svh]
// assertion helpers for the line rasterizer
`ifndef LINE_RASTERIZER_ASSERT_SVH
`define LINE_RASTERIZER_ASSERT_SVH

`ifndef SYNTHESIS

`define LR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define LR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define LR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)

`define LR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

[hw/rtl/lr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lr_pkg;

   localparam int CANVAS_SIZE = 2000;

   localparam int COORD_W  = 12;
   localparam int IN_W     = 13;
   localparam int PITCH_W  = 13;
   localparam int OFFSET_W = 24;
   localparam int ERR_W    = 15;
   localparam int WORD_W   = 32;

   localparam logic [PITCH_W-1:0] PITCH_RESET = PITCH_W'(2000);

   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   localparam logic [1:0] KIND_ACCEPT = 2'd0;
   localparam logic [1:0] KIND_REJECT = 2'd1;
   localparam logic [1:0] KIND_PIXEL  = 2'd2;
   localparam logic [1:0] KIND_IDLE   = 2'd3;

   typedef struct packed {
      logic              func;
      logic [IN_W-1:0]   start_col;
      logic [IN_W-1:0]   start_row;
      logic [IN_W-1:0]   stop_col;
      logic [IN_W-1:0]   stop_row;
      logic [WORD_W-1:0] line_colour;
   } req_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic [COORD_W-1:0]  pixel_col;
      logic [COORD_W-1:0]  pixel_row;
      logic [OFFSET_W-1:0] pixel_offset;
      logic [WORD_W-1:0]   pixel_word;
      logic                final_pixel;
   } rsp_type;

   function automatic logic [COORD_W-1:0] step_coord(input logic [COORD_W-1:0] v,
                                                      input logic neg);
      return neg ? v - COORD_W'(1) : v + COORD_W'(1);
   endfunction

   function automatic logic on_canvas(input logic [IN_W-1:0] v);
      return !v[IN_W-1] && ({1'b0, v[COORD_W-1:0]} < IN_W'(CANVAS_SIZE));
   endfunction

endpackage

`default_nettype wire

[hw/rtl/lr_in_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

module lr_in_stage
   import lr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire req_type in_txn,
   output logic         hold_valid,
   output req_type      hold_txn,
   input  wire logic    take
);

   logic    valid_ff, valid_in;
   req_type txn_ff;

   // a held transaction leaving this cycle frees the slot
   assign in_ready   = !valid_ff || take;
   assign hold_valid = valid_ff;
   assign hold_txn   = txn_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         txn_ff <= in_txn;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/lr_walker.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "line_rasterizer_assert.svh"

module lr_walker
   import lr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire req_type            txn,
   input  wire logic               take,
   input  wire logic [PITCH_W-1:0] pitch,
   output rsp_type                 result
);

   logic               active_ff, active_in;
   logic               y_major_ff, y_major_in;
   logic [COORD_W-1:0] cur_col_ff, cur_col_in;
   logic [COORD_W-1:0] cur_row_ff, cur_row_in;
   logic [COORD_W-1:0] goal_col_ff, goal_col_in;
   logic [COORD_W-1:0] goal_row_ff, goal_row_in;
   logic [COORD_W-1:0] span_x_ff, span_x_in;
   logic [COORD_W-1:0] span_y_ff, span_y_in;
   logic               dir_x_neg_ff, dir_x_neg_in;
   logic               dir_y_neg_ff, dir_y_neg_in;
   logic [ERR_W-1:0]   err_ff, err_in;
   logic [WORD_W-1:0]  colour_ff, colour_in;

   logic [COORD_W+PITCH_W-1:0] row_product;
   logic [OFFSET_W-1:0]        offset;

   assign row_product = (COORD_W + PITCH_W)'(cur_row_ff) * (COORD_W + PITCH_W)'(pitch);
   assign offset      = row_product[OFFSET_W-1:0] + OFFSET_W'(cur_col_ff);

   always_comb begin
      logic [IN_W-1:0]    dx, dy, adx, ady;
      logic [COORD_W-1:0] sx, sy, ncol, nrow;
      logic [ERR_W-1:0]   two_sx, two_sy, diag;
      logic               in_bounds, err_pos, err_neg;

      active_in    = active_ff;
      y_major_in   = y_major_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      goal_col_in  = goal_col_ff;
      goal_row_in  = goal_row_ff;
      span_x_in    = span_x_ff;
      span_y_in    = span_y_ff;
      dir_x_neg_in = dir_x_neg_ff;
      dir_y_neg_in = dir_y_neg_ff;
      err_in       = err_ff;
      colour_in    = colour_ff;
      result       = '0;

      dx  = txn.stop_col - txn.start_col;
      dy  = txn.stop_row - txn.start_row;
      adx = dx[IN_W-1] ? -dx : dx;
      ady = dy[IN_W-1] ? -dy : dy;
      sx  = adx[COORD_W-1:0];
      sy  = ady[COORD_W-1:0];
      in_bounds = on_canvas(txn.start_col) && on_canvas(txn.start_row)
                  && on_canvas(txn.stop_col) && on_canvas(txn.stop_row);

      // stepping terms come from the stored spans
      two_sx  = {2'b00, span_x_ff, 1'b0};
      two_sy  = {2'b00, span_y_ff, 1'b0};
      diag    = two_sy - two_sx;
      err_neg = err_ff[ERR_W-1];
      err_pos = !err_neg && (err_ff != '0);
      ncol    = step_coord(cur_col_ff, dir_x_neg_ff);
      nrow    = step_coord(cur_row_ff, dir_y_neg_ff);

      if (txn.func == FUNC_START) begin
         if (!in_bounds) begin
            result.kind = KIND_REJECT;
            active_in   = 1'b0;
         end else begin
            result.kind  = KIND_ACCEPT;
            dir_x_neg_in = dx[IN_W-1];
            dir_y_neg_in = dy[IN_W-1];
            span_x_in    = sx;
            span_y_in    = sy;
            cur_col_in   = txn.start_col[COORD_W-1:0];
            cur_row_in   = txn.start_row[COORD_W-1:0];
            goal_col_in  = txn.stop_col[COORD_W-1:0];
            goal_row_in  = txn.stop_row[COORD_W-1:0];
            colour_in    = txn.line_colour;
            y_major_in   = sy > sx;
            if (sy > sx) begin
               err_in    = {3'b000, sy} - {2'b00, sx, 1'b0};
               active_in = txn.start_row[COORD_W-1:0] != txn.stop_row[COORD_W-1:0];
            end else begin
               err_in    = {2'b00, sy, 1'b0} - {3'b000, sx};
               active_in = txn.start_col[COORD_W-1:0] != txn.stop_col[COORD_W-1:0];
            end
         end
      end else if (!active_ff) begin
         result.kind = KIND_IDLE;
      end else begin
         result.kind         = KIND_PIXEL;
         result.pixel_col    = cur_col_ff;
         result.pixel_row    = cur_row_ff;
         result.pixel_offset = offset;
         result.pixel_word   = colour_ff;
         if (y_major_ff) begin
            if (err_pos) begin
               err_in = err_ff - two_sx;
            end else begin
               cur_col_in = ncol;
               err_in     = err_ff + diag;
            end
            cur_row_in = nrow;
            active_in  = nrow != goal_row_ff;
         end else begin
            if (err_neg) begin
               err_in = err_ff + two_sy;
            end else begin
               cur_row_in = nrow;
               err_in     = err_ff + diag;
            end
            cur_col_in = ncol;
            active_in  = ncol != goal_col_ff;
         end
         result.final_pixel = !active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (take) begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         y_major_ff   <= y_major_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         goal_col_ff  <= goal_col_in;
         goal_row_ff  <= goal_row_in;
         span_x_ff    <= span_x_in;
         span_y_ff    <= span_y_in;
         dir_x_neg_ff <= dir_x_neg_in;
         dir_y_neg_ff <= dir_y_neg_in;
         err_ff       <= err_in;
         colour_ff    <= colour_in;
      end
   end

   `LR_ASSERT_NOW(a_walk_on_canvas, clock, reset, active_ff,
      (cur_col_ff < COORD_W'(CANVAS_SIZE)) && (cur_row_ff < COORD_W'(CANVAS_SIZE)),
      "walk left the canvas")

   `LR_ASSERT_NOW(a_err_bounded, clock, reset, active_ff,
      ($signed(err_ff) <= 15'sd8190) && ($signed(err_ff) >= -15'sd8190),
      "error term out of range")

   `LR_ASSERT_NEXT(a_final_ends_line, clock, reset,
      take && (result.kind == KIND_PIXEL) && result.final_pixel,
      !active_ff, "line still active after its last pixel")

   `LR_ASSERT_NOW(a_pixel_needs_line, clock, reset, result.kind == KIND_PIXEL,
      active_ff && (txn.func == FUNC_TICK), "pixel without an active line")

endmodule

`default_nettype wire

[hw/rtl/lr_out_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

module lr_out_stage
   import lr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    hold_valid,
   input  wire rsp_type result,
   output logic         take,
   output logic         out_valid,
   input  wire logic    out_ready,
   output rsp_type      out_rsp
);

   logic    valid_ff, valid_in;
   rsp_type rsp_ff;

   // load a new result whenever the slot is empty or being drained
   assign take      = hold_valid && (!valid_ff || out_ready);
   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= result;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/line_rasterizer.sv]
`timescale 1ns / 1ps
`default_nettype none

// Bresenham line rasterizer. A start transaction (func 0) loads both endpoints and
// the colour and answers accepted, or rejected when any coordinate is off the
// canvas; each tick transaction (func 1) answers with the next pixel (column, row,
// row*line_pitch+column offset modulo 2^24, colour, last-pixel flag) or idle when
// no line is active. The end point itself is never drawn. One transaction is taken
// every clock while rsp_ready does not stall the output, and each result passes
// through the input register and then the result register; the walk update, one
// add and compare plus the 12x13 offset multiply, sets that rate. line_pitch must be
// written through csr_wr_en/csr_wr_data while the block is idle (not enforced).
module line_rasterizer
   import lr_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,

   input  wire logic                csr_wr_en,
   input  wire logic [PITCH_W-1:0]  csr_wr_data,

   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_func,
   input  wire logic [IN_W-1:0]     req_start_col,
   input  wire logic [IN_W-1:0]     req_start_row,
   input  wire logic [IN_W-1:0]     req_stop_col,
   input  wire logic [IN_W-1:0]     req_stop_row,
   input  wire logic [WORD_W-1:0]   req_line_colour,

   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [1:0]               rsp_kind,
   output logic [COORD_W-1:0]       rsp_pixel_col,
   output logic [COORD_W-1:0]       rsp_pixel_row,
   output logic [OFFSET_W-1:0]      rsp_pixel_offset,
   output logic [WORD_W-1:0]        rsp_pixel_word,
   output logic                     rsp_final_pixel
);

   logic [PITCH_W-1:0] pitch_ff;
   req_type            in_txn, hold_txn;
   rsp_type            result, out_rsp;
   logic               hold_valid, take;

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_ff <= PITCH_RESET;
      end else if (csr_wr_en) begin
         pitch_ff <= csr_wr_data;
      end
   end

   assign in_txn.func        = req_func;
   assign in_txn.start_col   = req_start_col;
   assign in_txn.start_row   = req_start_row;
   assign in_txn.stop_col    = req_stop_col;
   assign in_txn.stop_row    = req_stop_row;
   assign in_txn.line_colour = req_line_colour;

   lr_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_txn     (in_txn),
      .hold_valid (hold_valid),
      .hold_txn   (hold_txn),
      .take       (take)
   );

   lr_walker u_walker (
      .clock  (clock),
      .reset  (reset),
      .txn    (hold_txn),
      .take   (take),
      .pitch  (pitch_ff),
      .result (result)
   );

   lr_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .hold_valid (hold_valid),
      .result     (result),
      .take       (take),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_rsp    (out_rsp)
   );

   assign rsp_kind         = out_rsp.kind;
   assign rsp_pixel_col    = out_rsp.pixel_col;
   assign rsp_pixel_row    = out_rsp.pixel_row;
   assign rsp_pixel_offset = out_rsp.pixel_offset;
   assign rsp_pixel_word   = out_rsp.pixel_word;
   assign rsp_final_pixel  = out_rsp.final_pixel;

endmodule

`default_nettype wire
